// ===== rtl/core/ttwv_pkg.sv =====
package ttwv_pkg;

	localparam int TIME_FRAC_BITS_DEF = 8;
	localparam int CORDIC_STEPS = 16;
	localparam int ADDR_W = 5;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_EDGE_DELAY  = 3'd0;
	localparam logic [2:0] REG_NS_BIAS     = 3'd1;
	localparam logic [2:0] REG_EW_BIAS     = 3'd2;
	localparam logic [2:0] REG_PATH_SCALE  = 3'd3;
	localparam logic [2:0] REG_BLEND_GAIN  = 3'd4;

	localparam logic [15:0] EDGE_DELAY_RST  = 16'd25088;
	localparam logic [15:0] NS_BIAS_RST     = 16'd335;
	localparam logic [15:0] EW_BIAS_RST     = 16'd236;
	localparam logic [19:0] PATH_SCALE_RST  = 20'd293453;
	localparam logic [15:0] BLEND_GAIN_RST  = 16'd6554;

	localparam logic [9:0] UM_PER_MM = 10'd1000;

	typedef struct packed {
		logic [15:0] edge_delay;
		logic [15:0] ns_bias;
		logic [15:0] ew_bias;
		logic [19:0] path_scale;
		logic [15:0] blend_gain;
	} cfg_t;

	// arctan(2^-i) in 1/65536 hundredths of a degree
	function automatic logic [28:0] atan_lut(input logic [3:0] idx);
		logic [28:0] v;
		unique case (idx)
			4'd0:  v = 29'd294912000;
			4'd1:  v = 29'd174096719;
			4'd2:  v = 29'd91987925;
			4'd3:  v = 29'd46694507;
			4'd4:  v = 29'd23437865;
			4'd5:  v = 29'd11730358;
			4'd6:  v = 29'd5866610;
			4'd7:  v = 29'd2933484;
			4'd8:  v = 29'd1466765;
			4'd9:  v = 29'd733385;
			4'd10: v = 29'd366693;
			4'd11: v = 29'd183347;
			4'd12: v = 29'd91673;
			4'd13: v = 29'd45837;
			4'd14: v = 29'd22918;
			4'd15: v = 29'd11459;
			default: v = 29'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/ttwv_regs.sv =====
module ttwv_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ttwv_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output ttwv_pkg::cfg_t              cfg
);

	ttwv_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[ttwv_pkg::ADDR_W-1:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_delay  <= ttwv_pkg::EDGE_DELAY_RST;
			cfg_q.ns_bias     <= ttwv_pkg::NS_BIAS_RST;
			cfg_q.ew_bias     <= ttwv_pkg::EW_BIAS_RST;
			cfg_q.path_scale  <= ttwv_pkg::PATH_SCALE_RST;
			cfg_q.blend_gain  <= ttwv_pkg::BLEND_GAIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				ttwv_pkg::REG_EDGE_DELAY:  cfg_q.edge_delay  <= pwdata[15:0];
				ttwv_pkg::REG_NS_BIAS:     cfg_q.ns_bias     <= pwdata[15:0];
				ttwv_pkg::REG_EW_BIAS:     cfg_q.ew_bias     <= pwdata[15:0];
				ttwv_pkg::REG_PATH_SCALE:  cfg_q.path_scale  <= pwdata[19:0];
				ttwv_pkg::REG_BLEND_GAIN:  cfg_q.blend_gain  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ttwv_pkg::REG_EDGE_DELAY:  prdata = {16'd0, cfg_q.edge_delay};
			ttwv_pkg::REG_NS_BIAS:     prdata = {16'd0, cfg_q.ns_bias};
			ttwv_pkg::REG_EW_BIAS:     prdata = {16'd0, cfg_q.ew_bias};
			ttwv_pkg::REG_PATH_SCALE:  prdata = {12'd0, cfg_q.path_scale};
			ttwv_pkg::REG_BLEND_GAIN:  prdata = {16'd0, cfg_q.blend_gain};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/core/ttwv_mul.sv =====
module ttwv_mul (
	input  logic               clk,
	input  logic signed [34:0] a,
	input  logic signed [32:0] b,
	output logic signed [67:0] p_q
);

	// registered product, available in the cycle after its operands
	always_ff @(posedge clk) begin
		p_q <= 68'(a) * 68'(b);
	end

endmodule

// ===== rtl/core/transit_time_wind_vector_estimator_unit.sv =====
// Channel  | Beat moved on                      | Payload
// ---------+------------------------------------+------------------------------------------
// in       | in_valid & !in_stall               | t_north_south, t_south_north,
//          |                                    | t_east_west, t_west_east
// out      | out_valid & !out_stall             | speed, direction, vel_east_west,
//          |                                    | vel_north_south
// cfg      | psel & penable & pwrite (pready=1) | paddr, pwdata, prdata
//
// An item holds in_stall from its accept edge until the sequencer is idle again. A warmup
// item runs two axes (three multiplier passes, a divisor load, a 16-step restoring divide)
// and one warmup check; an emitting item then adds blend and squaring on the same
// multiplier, a 32-step root, a 16-step CORDIC (skipped with a zero east-west estimate)
// and a post state. A result waits in the output register; while it is stalled, the
// next result holds the sequencer in its final state. Reset loads register defaults.
module transit_time_wind_vector_estimator_unit #(
	parameter int TIME_FRAC_BITS = ttwv_pkg::TIME_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [19:0]                 t_north_south,
	input  logic [19:0]                 t_south_north,
	input  logic [19:0]                 t_east_west,
	input  logic [19:0]                 t_west_east,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [15:0]                 speed,
	output logic [15:0]                 direction,
	output logic signed [16:0]          vel_east_west,
	output logic signed [16:0]          vel_north_south,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ttwv_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	// numerator width: path_scale*1000*diff (52 bits) scaled by the time resolution
	localparam int NUM_W = 52 + TIME_FRAC_BITS + 1;
	localparam int CW    = NUM_W + 4;
	localparam logic signed [22:0] LIM = 23'(1 << (TIME_FRAC_BITS + 1));

	typedef enum logic [15:0] {
		S_IDLE  = 16'b0000_0000_0000_0001,
		S_AB    = 16'b0000_0000_0000_0010,
		S_PM    = 16'b0000_0000_0000_0100,
		S_NUM   = 16'b0000_0000_0000_1000,
		S_DEN   = 16'b0000_0000_0001_0000,
		S_DIV   = 16'b0000_0000_0010_0000,
		S_POST  = 16'b0000_0000_0100_0000,
		S_BL0   = 16'b0000_0000_1000_0000,
		S_BL1   = 16'b0000_0001_0000_0000,
		S_BL2   = 16'b0000_0010_0000_0000,
		S_SQ1   = 16'b0000_0100_0000_0000,
		S_SQ2   = 16'b0000_1000_0000_0000,
		S_SQRT  = 16'b0001_0000_0000_0000,
		S_CINIT = 16'b0010_0000_0000_0000,
		S_CORD  = 16'b0100_0000_0000_0000,
		S_EMIT  = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;

	ttwv_pkg::cfg_t cfg;

	ttwv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// shared multiplier
	logic signed [34:0] ma;
	logic signed [32:0] mb;
	logic signed [67:0] prod_q;

	ttwv_mul u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.p_q (prod_q)
	);

	// captured item and per-axis working registers
	logic [19:0]        tns_q, tsn_q, tew_q, twe_q;
	logic               axis_q;
	logic [21:0]        a_q, b_q, diff_q;
	logic               zero_q, neg_q, sat_q;
	logic [NUM_W-1:0]   num_q;
	logic [CW-1:0]      rem_q, dsh_q;
	logic [15:0]        quo_q;
	logic [4:0]         cnt_q;
	logic signed [16:0] vx_q, vy_q;
	logic [1:0]         warm_q;
	logic signed [31:0] ex_q, ey_q;
	logic [63:0]        sum_q, rt_q, bit_q;
	logic signed [35:0] u_q, w_q;
	logic signed [33:0] z_q;
	logic               base_q;

	// output register
	logic               out_valid_q;
	logic [15:0]        spd_q;
	logic [15:0]        speed_q, dir_q;
	logic signed [16:0] vew_q, vns_q;

	// axis selection and corrected doubled times
	logic [19:0]        tf, tr;
	logic [15:0]        bias;
	logic signed [22:0] a_w, b_w, bias_w, rise_w;
	logic               zero_w, neg_w;
	logic [22:0]        diff_w;

	always_comb begin
		tf     = axis_q ? tew_q : tns_q;
		tr     = axis_q ? twe_q : tsn_q;
		bias   = axis_q ? cfg.ew_bias : cfg.ns_bias;
		bias_w = {{7{bias[15]}}, bias};
		rise_w = {6'd0, cfg.edge_delay, 1'b0};
		a_w    = $signed({2'd0, tf, 1'b0}) - rise_w - bias_w;
		b_w    = $signed({2'd0, tr, 1'b0}) - rise_w + bias_w;
		zero_w = (a_w <= LIM) || (b_w <= LIM) || (a_w == b_w);
		neg_w  = a_w > b_w;
		diff_w = neg_w ? 23'(a_w - b_w) : 23'(b_w - a_w);
	end

	// divide step
	logic          div_ge;
	logic [15:0]   quo_next;
	logic [15:0]   mag;
	logic signed [16:0] vel_w;

	always_comb begin
		div_ge   = rem_q >= dsh_q;
		quo_next = {quo_q[14:0], div_ge};
		mag      = sat_q ? 16'hFFFF : quo_next;
		if (zero_q) begin
			vel_w = 17'sd0;
		end else if (neg_q) begin
			vel_w = -$signed({1'b0, mag});
		end else begin
			vel_w = $signed({1'b0, mag});
		end
	end

	// blend differences: m*2^15 - e
	logic signed [34:0] dx, dy;
	assign dx = $signed({{3{vx_q[16]}}, vx_q, 15'd0}) - 35'(ex_q);
	assign dy = $signed({{3{vy_q[16]}}, vy_q, 15'd0}) - 35'(ey_q);

	// multiplier operand selection
	always_comb begin
		ma = 35'sd0;
		mb = 33'sd0;
		unique case (state_q)
			S_AB: begin
				ma = $signed(35'(cfg.path_scale));
				mb = $signed(33'(ttwv_pkg::UM_PER_MM));
			end
			S_PM: begin
				ma = $signed(35'(prod_q[29:0]));
				mb = $signed(33'(diff_q));
			end
			S_NUM: begin
				ma = $signed(35'(a_q));
				mb = $signed(33'(b_q));
			end
			S_BL0: begin
				ma = dx;
				mb = $signed(33'(cfg.blend_gain));
			end
			S_BL1: begin
				ma = dy;
				mb = $signed(33'(cfg.blend_gain));
			end
			S_BL2: begin
				ma = 35'(ex_q);
				mb = 33'(ex_q);
			end
			S_SQ1: begin
				ma = 35'(ey_q);
				mb = 33'(ey_q);
			end
			default: ;
		endcase
	end

	logic signed [67:0] gain_sh;
	assign gain_sh = prod_q >>> 16;

	// square root step
	logic [64:0] sq_t;
	logic        sq_ge;
	assign sq_t  = {1'b0, rt_q} + {1'b0, bit_q};
	assign sq_ge = {1'b0, sum_q} >= sq_t;

	// rounded speed
	logic [64:0] spd_w;
	assign spd_w = ({1'b0, rt_q} + 65'd16384) >> 15;

	// CORDIC step
	logic [3:0]         ci;
	logic signed [35:0] cdu, cdw;
	logic signed [33:0] cat;
	assign ci  = cnt_q[3:0];
	assign cdu = w_q >>> ci;
	assign cdw = u_q >>> ci;
	assign cat = $signed(34'(ttwv_pkg::atan_lut(ci)));

	// direction: round, floor to hundredths, wrap into one turn
	logic signed [33:0] dsum;
	logic signed [17:0] dr, dwrap;
	always_comb begin
		dsum = z_q + 34'sd32768 + (base_q ? 34'sd1179648000 : 34'sd0);
		dr   = 18'(dsum >>> 16);
		if (dr < 18'sd0) begin
			dwrap = dr + 18'sd36000;
		end else if (dr >= 18'sd36000) begin
			dwrap = dr - 18'sd36000;
		end else begin
			dwrap = dr;
		end
	end

	// component rounding
	logic signed [32:0] exr, eyr;
	assign exr = (33'(ex_q) + 33'sd16384) >>> 15;
	assign eyr = (33'(ey_q) + 33'sd16384) >>> 15;

	logic emit_ok;
	assign emit_ok = !out_valid_q || !out_stall;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			cnt_q       <= 5'd0;
			warm_q      <= 2'd0;
			ex_q        <= 32'sd0;
			ey_q        <= 32'sd0;
			out_valid_q <= 1'b0;
		end else begin
			// post a new beat, or drop the one taken this cycle
			if (state_q == S_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						axis_q  <= 1'b0;
						state_q <= S_AB;
					end
				end
				S_AB:  state_q <= S_PM;
				S_PM:  state_q <= S_NUM;
				S_NUM: state_q <= S_DEN;
				S_DEN: begin
					cnt_q   <= 5'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= S_AB;
						end else begin
							state_q <= S_POST;
						end
					end
				end
				S_POST: begin
					// drop the first item, seed on the second
					priority if (warm_q == 2'd0) begin
						warm_q  <= 2'd1;
						state_q <= S_IDLE;
					end else if (warm_q == 2'd1) begin
						warm_q  <= 2'd2;
						ex_q    <= {vx_q, 15'd0};
						ey_q    <= {vy_q, 15'd0};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BL0;
					end
				end
				S_BL0: state_q <= S_BL1;
				S_BL1: begin
					ex_q    <= ex_q + gain_sh[31:0];
					state_q <= S_BL2;
				end
				S_BL2: begin
					ey_q    <= ey_q + gain_sh[31:0];
					state_q <= S_SQ1;
				end
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: begin
					cnt_q   <= 5'd0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= S_CINIT;
					end
				end
				S_CINIT: begin
					cnt_q   <= 5'd0;
					state_q <= (ex_q == 32'sd0) ? S_EMIT : S_CORD;
				end
				S_CORD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				tns_q <= t_north_south;
				tsn_q <= t_south_north;
				tew_q <= t_east_west;
				twe_q <= t_west_east;
			end
			S_AB: begin
				a_q    <= a_w[21:0];
				b_q    <= b_w[21:0];
				diff_q <= diff_w[21:0];
				zero_q <= zero_w;
				neg_q  <= neg_w;
			end
			S_NUM: begin
				num_q <= NUM_W'(prod_q[51:0]) << (TIME_FRAC_BITS + 1);
			end
			S_DEN: begin
				sat_q <= CW'(num_q) >= (CW'(prod_q[43:0]) << 16);
				rem_q <= CW'(num_q);
				dsh_q <= CW'(prod_q[43:0]) << 15;
				quo_q <= 16'd0;
			end
			S_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_next;
				if (cnt_q == 5'd15) begin
					if (!axis_q) begin
						vy_q <= vel_w;
					end else begin
						vx_q <= vel_w;
					end
				end
			end
			S_SQ1: begin
				sum_q <= prod_q[63:0];
			end
			S_SQ2: begin
				sum_q <= sum_q + prod_q[63:0];
				rt_q  <= 64'd0;
				bit_q <= 64'd1 << 62;
			end
			S_SQRT: begin
				if (sq_ge) begin
					sum_q <= sum_q - sq_t[63:0];
					rt_q  <= (rt_q >> 1) + bit_q;
				end else begin
					rt_q  <= rt_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_CINIT: begin
				spd_q  <= (spd_w > 65'd65535) ? 16'hFFFF : spd_w[15:0];
				z_q    <= 34'sd0;
				base_q <= ey_q < 32'sd0;
				if (ey_q < 32'sd0) begin
					u_q <= -36'(ey_q);
					w_q <= -36'(ex_q);
				end else begin
					u_q <= 36'(ey_q);
					w_q <= 36'(ex_q);
				end
			end
			S_CORD: begin
				if (w_q > 36'sd0) begin
					u_q <= u_q + cdu;
					w_q <= w_q - cdw;
					z_q <= z_q + cat;
				end else begin
					u_q <= u_q - cdu;
					w_q <= w_q + cdw;
					z_q <= z_q - cat;
				end
			end
			S_EMIT: begin
				if (emit_ok) begin
					speed_q <= spd_q;
					dir_q   <= 16'(dwrap);
					vew_q   <= exr[16:0];
					vns_q   <= eyr[16:0];
				end
			end
			default: ;
		endcase
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign speed           = speed_q;
	assign direction       = dir_q;
	assign vel_east_west   = vew_q;
	assign vel_north_south = vns_q;

endmodule
